// ===== rtl/core/escpwm_pkg.sv =====
`timescale 1ns / 1ps

package escpwm_pkg;

    // Capture and duration widths
    localparam int CAPTURE_BITS  = 16;
    localparam int TICK_NS_BITS  = 10;
    localparam int NS_BITS       = CAPTURE_BITS + TICK_NS_BITS;
    localparam int PROTO_BITS    = 3;
    localparam int THR_BITS      = 12;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [THR_BITS-1:0] THR_FULL = 12'h800;

    // Protocol codes, shared by the active_protocol register and the result
    typedef enum logic [PROTO_BITS-1:0] {
        PROTO_NONE         = 3'd0,
        PROTO_CONVENTIONAL = 3'd1,
        PROTO_ONESHOT125   = 3'd2,
        PROTO_ONESHOT42    = 3'd3,
        PROTO_MULTISHOT    = 3'd4,
        PROTO_UNKNOWN      = 3'd5
    } t_protocol;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_PROTOCOL       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TICK_PERIOD_NS        = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIGITAL_PERIOD_MAX    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MULTISHOT_DUTY_MAX    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ONESHOT42_DUTY_MAX    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ONESHOT125_DUTY_MAX   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONVENTIONAL_DUTY_MAX = 3'd6;

    // Fixed throttle windows, duty in ns
    localparam logic [NS_BITS-1:0] CONV_LO  = 26'd1000000;
    localparam logic [NS_BITS-1:0] CONV_HI  = 26'd2000000;
    localparam logic [NS_BITS-1:0] OS125_LO = 26'd125000;
    localparam logic [NS_BITS-1:0] OS125_HI = 26'd250000;
    localparam logic [NS_BITS-1:0] OS42_LO  = 26'd42000;
    localparam logic [NS_BITS-1:0] OS42_HI  = 26'd84000;
    localparam logic [NS_BITS-1:0] MS_LO    = 26'd5000;
    localparam logic [NS_BITS-1:0] MS_HI    = 26'd25000;

    // 2048 * x / width reduced to (x << shift) / divisor per window
    localparam int X_BITS      = 20;
    localparam int NUM_BITS    = 25;
    localparam int SHIFT_CONV  = 5;
    localparam int SHIFT_OS125 = 8;
    localparam int SHIFT_OS42  = 7;
    localparam int SHIFT_MS    = 6;

    localparam int RECIP_SHIFT = 40;
    localparam int RECIP_BITS  = 31;
    localparam int PROD_BITS   = NUM_BITS + RECIP_BITS;

    localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;
    localparam logic [63:0] DIV_CONV  = 64'd15625;
    localparam logic [63:0] DIV_OS125 = 64'd15625;
    localparam logic [63:0] DIV_OS42  = 64'd2625;
    localparam logic [63:0] DIV_MS    = 64'd625;

    // Rounded-up reciprocals; exact for every numerator below 2^NUM_BITS
    localparam logic [RECIP_BITS-1:0] RECIP_CONV  =
        RECIP_BITS'((RECIP_ONE + DIV_CONV - 64'd1) / DIV_CONV);
    localparam logic [RECIP_BITS-1:0] RECIP_OS125 =
        RECIP_BITS'((RECIP_ONE + DIV_OS125 - 64'd1) / DIV_OS125);
    localparam logic [RECIP_BITS-1:0] RECIP_OS42  =
        RECIP_BITS'((RECIP_ONE + DIV_OS42 - 64'd1) / DIV_OS42);
    localparam logic [RECIP_BITS-1:0] RECIP_MS    =
        RECIP_BITS'((RECIP_ONE + DIV_MS - 64'd1) / DIV_MS);

    typedef enum logic [1:0] {
        WIN_CONV,
        WIN_OS125,
        WIN_OS42,
        WIN_MS
    } t_window;

    typedef enum logic [1:0] {
        THR_ZERO,
        THR_SAT,
        THR_SCALE
    } t_thr_mode;

    typedef struct packed {
        logic [CAPTURE_BITS-1:0] period_ticks;
        logic [CAPTURE_BITS-1:0] duty_ticks;
        logic                    timed_out;
    } t_in_item;

    typedef struct packed {
        logic [PROTO_BITS-1:0] detected_protocol;
        logic [THR_BITS-1:0]   throttle;
        logic                  signal_valid;
    } t_result;

    typedef struct packed {
        logic [PROTO_BITS-1:0]    active_protocol;
        logic [TICK_NS_BITS-1:0]  tick_period_ns;
        logic [CFG_DATA_BITS-1:0] digital_limit_ns;
        logic [CFG_DATA_BITS-1:0] ms_limit_ns;
        logic [CFG_DATA_BITS-1:0] os42_limit_ns;
        logic [CFG_DATA_BITS-1:0] os125_limit_ns;
        logic [CFG_DATA_BITS-1:0] conv_limit_ns;
    } t_cfg;

    // Classified pulse on its way to the scaler
    typedef struct packed {
        logic [PROTO_BITS-1:0] detected_protocol;
        logic                  signal_valid;
        t_thr_mode             thr_mode;
        t_window               window;
        logic [NUM_BITS-1:0]   numer;
    } t_mid;

endpackage

// ===== rtl/core/escpwm_classify.sv =====
`timescale 1ns / 1ps

module escpwm_classify (
    input  escpwm_pkg::t_in_item i_item,
    input  escpwm_pkg::t_cfg     i_cfg,
    output escpwm_pkg::t_mid     o_mid
);
    import escpwm_pkg::*;

    logic [NS_BITS-1:0]       period_ns;
    logic [NS_BITS-1:0]       duty_ns;
    logic [CFG_DATA_BITS-1:0] period_ext;
    logic [CFG_DATA_BITS-1:0] duty_ext;
    logic [PROTO_BITS-1:0]    proto;
    logic [NS_BITS-1:0]       win_lo;
    logic [NS_BITS-1:0]       win_hi;
    logic                     win_active;
    t_window                  window;
    t_thr_mode                thr_mode;
    logic [X_BITS-1:0]        offset;
    logic [NUM_BITS-1:0]      offset_ext;
    logic [NUM_BITS-1:0]      numer;

    assign period_ns  = NS_BITS'(i_item.period_ticks) * NS_BITS'(i_cfg.tick_period_ns);
    assign duty_ns    = NS_BITS'(i_item.duty_ticks) * NS_BITS'(i_cfg.tick_period_ns);
    assign period_ext = CFG_DATA_BITS'(period_ns);
    assign duty_ext   = CFG_DATA_BITS'(duty_ns);

    always_comb begin
        if (period_ns == '0) begin
            proto = PROTO_NONE;
        end else if (period_ext < i_cfg.digital_limit_ns) begin
            proto = PROTO_UNKNOWN;
        end else if (duty_ns == '0) begin
            proto = PROTO_NONE;
        end else if (duty_ext < i_cfg.ms_limit_ns) begin
            proto = PROTO_MULTISHOT;
        end else if (duty_ext < i_cfg.os42_limit_ns) begin
            proto = PROTO_ONESHOT42;
        end else if (duty_ext < i_cfg.os125_limit_ns) begin
            proto = PROTO_ONESHOT125;
        end else if (duty_ext < i_cfg.conv_limit_ns) begin
            proto = PROTO_CONVENTIONAL;
        end else begin
            proto = PROTO_UNKNOWN;
        end
    end

    always_comb begin
        win_lo     = CONV_LO;
        win_hi     = CONV_HI;
        window     = WIN_CONV;
        win_active = 1'b1;
        case (i_cfg.active_protocol)
            PROTO_CONVENTIONAL: begin
                win_lo = CONV_LO;
                win_hi = CONV_HI;
                window = WIN_CONV;
            end
            PROTO_ONESHOT125: begin
                win_lo = OS125_LO;
                win_hi = OS125_HI;
                window = WIN_OS125;
            end
            PROTO_ONESHOT42: begin
                win_lo = OS42_LO;
                win_hi = OS42_HI;
                window = WIN_OS42;
            end
            PROTO_MULTISHOT: begin
                win_lo = MS_LO;
                win_hi = MS_HI;
                window = WIN_MS;
            end
            default: begin
                win_active = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (!win_active || duty_ns < win_lo) begin
            thr_mode = THR_ZERO;
        end else if (duty_ns > win_hi) begin
            thr_mode = THR_SAT;
        end else begin
            thr_mode = THR_SCALE;
        end
    end

    // Offset into the window fits X_BITS whenever the scaler uses it
    assign offset     = X_BITS'(duty_ns - win_lo);
    assign offset_ext = NUM_BITS'(offset);

    always_comb begin
        case (window)
            WIN_CONV:  numer = offset_ext << SHIFT_CONV;
            WIN_OS125: numer = offset_ext << SHIFT_OS125;
            WIN_OS42:  numer = offset_ext << SHIFT_OS42;
            WIN_MS:    numer = offset_ext << SHIFT_MS;
            default:   numer = offset_ext;
        endcase
    end

    assign o_mid.detected_protocol = proto;
    assign o_mid.signal_valid      = ~i_item.timed_out;
    assign o_mid.thr_mode          = thr_mode;
    assign o_mid.window            = window;
    assign o_mid.numer             = numer;

endmodule

// ===== rtl/core/escpwm_scale.sv =====
`timescale 1ns / 1ps

module escpwm_scale (
    input  escpwm_pkg::t_mid                   i_mid,
    output logic [escpwm_pkg::THR_BITS-1:0]    o_throttle
);
    import escpwm_pkg::*;

    logic [RECIP_BITS-1:0] recip;
    logic [PROD_BITS-1:0]  product;
    logic [THR_BITS-1:0]   quotient;

    always_comb begin
        case (i_mid.window)
            WIN_CONV:  recip = RECIP_CONV;
            WIN_OS125: recip = RECIP_OS125;
            WIN_OS42:  recip = RECIP_OS42;
            WIN_MS:    recip = RECIP_MS;
            default:   recip = RECIP_CONV;
        endcase
    end

    // Divide by the window's constant through its reciprocal
    assign product  = PROD_BITS'(i_mid.numer) * PROD_BITS'(recip);
    assign quotient = product[RECIP_SHIFT +: THR_BITS];

    always_comb begin
        case (i_mid.thr_mode)
            THR_ZERO:  o_throttle = '0;
            THR_SAT:   o_throttle = THR_FULL;
            THR_SCALE: o_throttle = quotient;
            default:   o_throttle = '0;
        endcase
    end

endmodule

// ===== rtl/core/esc_pwm_protocol_classify_throttle.sv =====
`timescale 1ns / 1ps

// Servo-style pulse decoder for an ESC input.
// Input channel: one captured pulse per transaction (period and high time in
// capture ticks, plus a timeout flag), accepted when i_in_valid is high and
// o_in_stall is low. Output channel: one result per pulse (detected protocol,
// throttle 0..2048, signal_valid), taken when o_out_valid is high and
// i_out_stall is low.
// Configuration: write i_cfg_wdata to register i_cfg_index while i_cfg_we is
// high; only while no pulse is in flight. Indexes above six are ignored.
// A pulse passes the input register, the classify register and the result
// register in that order before its result is presented.
// Throughput: one pulse per cycle unless stalled; the tick multipliers sit
// in the classify stage and the reciprocal multiplier in the result stage.
// Reset (synchronous, active low) empties the pipeline and loads the
// register defaults; o_in_stall is held high during reset.
// A stalled result holds; the stages behind it keep filling, and o_in_stall
// rises only once all three stages are full.
module esc_pwm_protocol_classify_throttle (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  escpwm_pkg::t_in_item                 i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output escpwm_pkg::t_result                  o_out_result,
    input  logic                                 i_cfg_we,
    input  logic [escpwm_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [escpwm_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata
);
    import escpwm_pkg::*;

    t_cfg                r_cfg;
    logic                r_in_valid;
    t_in_item            r_in_item;
    logic                r_mid_valid;
    t_mid                r_mid;
    logic                r_out_valid;
    t_result             r_out;

    t_mid                n_mid;
    t_result             n_out;
    logic [THR_BITS-1:0] throttle;
    logic                out_ready;
    logic                mid_ready;
    logic                in_ready;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign mid_ready = !r_mid_valid || out_ready;
    assign in_ready  = !r_in_valid || mid_ready;

    assign o_in_stall   = !in_ready || !i_rst_n;
    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_protocol  <= PROTO_NONE;
            r_cfg.tick_period_ns   <= 10'd500;
            r_cfg.digital_limit_ns <= 32'd31250;
            r_cfg.ms_limit_ns      <= 32'd30000;
            r_cfg.os42_limit_ns    <= 32'd100000;
            r_cfg.os125_limit_ns   <= 32'd300000;
            r_cfg.conv_limit_ns    <= 32'd2500000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACTIVE_PROTOCOL:
                    r_cfg.active_protocol <= i_cfg_wdata[PROTO_BITS-1:0];
                CFG_TICK_PERIOD_NS:
                    r_cfg.tick_period_ns <= i_cfg_wdata[TICK_NS_BITS-1:0];
                CFG_DIGITAL_PERIOD_MAX:
                    r_cfg.digital_limit_ns <= i_cfg_wdata;
                CFG_MULTISHOT_DUTY_MAX:
                    r_cfg.ms_limit_ns <= i_cfg_wdata;
                CFG_ONESHOT42_DUTY_MAX:
                    r_cfg.os42_limit_ns <= i_cfg_wdata;
                CFG_ONESHOT125_DUTY_MAX:
                    r_cfg.os125_limit_ns <= i_cfg_wdata;
                CFG_CONVENTIONAL_DUTY_MAX:
                    r_cfg.conv_limit_ns <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Pipeline valids: advance a stage when the one ahead is free or moving
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (mid_ready) begin
                r_mid_valid <= r_in_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_mid_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (mid_ready && r_in_valid) begin
            r_mid <= n_mid;
        end
        if (out_ready && r_mid_valid) begin
            r_out <= n_out;
        end
    end

    escpwm_classify u_classify (
        .i_item (r_in_item),
        .i_cfg  (r_cfg),
        .o_mid  (n_mid)
    );

    escpwm_scale u_scale (
        .i_mid      (r_mid),
        .o_throttle (throttle)
    );

    assign n_out.detected_protocol = r_mid.detected_protocol;
    assign n_out.throttle          = throttle;
    assign n_out.signal_valid      = r_mid.signal_valid;

    // Throttle never leaves the 0..2048 range
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_result.throttle <= THR_FULL))
        else $error("throttle above full scale");

    // No throttle when the active protocol has no window
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_cfg.active_protocol != PROTO_CONVENTIONAL
         && r_cfg.active_protocol != PROTO_ONESHOT125
         && r_cfg.active_protocol != PROTO_ONESHOT42
         && r_cfg.active_protocol != PROTO_MULTISHOT)
        |-> (o_out_result.throttle == '0))
        else $error("throttle without an active window");

    // Input stalls only when every stage is full and the output is held
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_mid_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

    // A pulse in the classify stage reaches the result register next cycle when out_ready is high
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid_valid && out_ready) |=> o_out_valid)
        else $error("classified pulse lost");

endmodule
